@@ src/rdem_pkg.sv @@
// Shared types, opcodes and constants for the execute stage with HI/LO unit.
package rdem_pkg;

  localparam int XLEN = 32;
  localparam int CNT_W = 6;

  // configuration register indexes
  localparam logic [0:0] CFG_MUL_LAT = 1'd0;
  localparam logic [0:0] CFG_DIV_LAT = 1'd1;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE   = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDI_U  = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTI_U  = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // R-type function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // memory access kinds
  localparam logic [3:0] MK_NONE = 4'd0;
  localparam logic [3:0] MK_LW   = 4'd1;
  localparam logic [3:0] MK_LH   = 4'd2;
  localparam logic [3:0] MK_LHU  = 4'd3;
  localparam logic [3:0] MK_LB   = 4'd4;
  localparam logic [3:0] MK_LBU  = 4'd5;
  localparam logic [3:0] MK_SW   = 4'd6;
  localparam logic [3:0] MK_SH   = 4'd7;
  localparam logic [3:0] MK_SB   = 4'd8;

  localparam logic [4:0] REG_RA = 5'd31;

  typedef struct packed {
    logic        cmd;
    logic [31:0] instr_word;
    logic [31:0] pc_value;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        br_flag;
    logic        br_taken;
    logic [31:0] branch_target;
    logic [3:0]  mem_kind;
    logic [31:0] mem_address;
    logic [31:0] store_data;
  } out_item_t;

  // muldiv unit request / response
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic        is_signed;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

endpackage

@@ src/rdem_if.sv @@
// Valid/ready channel interfaces for input and result items.
interface rdem_in_if import rdem_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdem_out_if import rdem_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/risc_decode_execute_muldiv.sv @@
// Top level: integer execute stage with HI/LO multiply/divide unit.
//
// Usage:
//   in_*  : one transfer per tick item (cmd, instr_word, pc_value, rs/rt).
//   out_* : one result transfer per input transfer, in order.
//   cfg_* : write port; index 0 = mul_latency, 1 = div_latency (6 bits).
// Flow:
//   Most instructions: result registered in the cycle after the input transfer;
//   next input taken once the result has been transferred out.
//   MULT/MULTU/DIV/DIVU: run on one shared shift-add/subtract unit, one bit
//   per cycle: 32 steps, a sign fixup and the done handoff come between the
//   input transfer and the result; the next input waits for its transfer out.
// busy_count models the architectural HI/LO interlock: it drops by one per
//   input transfer (tick) and MFHI/MFLO/MTHI/MTLO are refused while the count after that drop is nonzero.
// Reset: HI/LO and busy count clear, latencies go to 4 and 32, output empty.
// Receiver stall: the result holds in the output register; in_ready stays
//   low until it is transferred.
module risc_decode_execute_muldiv import rdem_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  rdem_in_if.sink       in_ch,
  rdem_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [5:0]    cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [31:0]      hi_r, lo_r;
  logic [CNT_W-1:0] busy_r, mul_lat_r, div_lat_r;
  logic [CNT_W-1:0] busy_dec;
  out_item_t        res_r;
  out_item_t        alu_res;
  logic             is_md, md_div, md_signed, wr_hi, wr_lo;
  md_req_t          md_req;
  md_rsp_t          md_rsp;
  logic             in_fire;

  assign busy_dec = (busy_r != '0) ? busy_r - 6'd1 : busy_r;

  rdem_alu u_alu (
    .item      (in_ch.data),
    .hi        (hi_r),
    .lo        (lo_r),
    .busy      (busy_dec != '0),
    .res       (alu_res),
    .is_md     (is_md),
    .md_div    (md_div),
    .md_signed (md_signed),
    .wr_hi     (wr_hi),
    .wr_lo     (wr_lo)
  );

  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    md_req.start     = in_fire && is_md;
    md_req.is_div    = md_div;
    md_req.is_signed = md_signed;
    md_req.a         = in_ch.data.rs_value;
    md_req.b         = in_ch.data.rt_value;
  end

  rdem_muldiv u_md (
    .clk (clk),
    .rst_n (rst_n),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = is_md ? S_MD : S_OUT;
      S_MD:   if (md_rsp.done) state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      hi_r      <= '0;
      lo_r      <= '0;
      busy_r    <= '0;
      mul_lat_r <= 6'd4;
      div_lat_r <= 6'd32;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_MUL_LAT) mul_lat_r <= cfg_data;
        else div_lat_r <= cfg_data;
      end
      if (in_fire) begin
        if (is_md) busy_r <= md_div ? div_lat_r : mul_lat_r;
        else busy_r <= busy_dec;
        if (wr_hi) hi_r <= in_ch.data.rs_value;
        if (wr_lo) lo_r <= in_ch.data.rs_value;
      end
      if (state_r == S_MD && md_rsp.done) begin
        hi_r <= md_rsp.hi;
        lo_r <= md_rsp.lo;
      end
    end
    if (in_fire) res_r <= alu_res;
  end

endmodule

@@ src/rdem_muldiv.sv @@
// Shared iterative multiply/divide unit: one shift-add or shift-subtract step per cycle.
module rdem_muldiv import rdem_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        is_div_r, is_div_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic        zero_r, zero_nxt;
  logic [31:0] acc_r, acc_nxt;   // high half / remainder
  logic [31:0] sh_r, sh_nxt;     // multiplier / dividend -> low half / quotient
  logic [31:0] opb_r, opb_nxt;   // multiplicand / divisor
  logic        done_r, done_nxt;

  logic        na, nb;
  logic [31:0] ua, ub;
  logic [32:0] add_res;
  logic [32:0] rem_sh;
  logic [32:0] sub_res;
  logic [63:0] prod;

  always_comb begin
    na = req.is_signed & req.a[31];
    nb = req.is_signed & req.b[31];
    ua = na ? (32'd0 - req.a) : req.a;
    ub = nb ? (32'd0 - req.b) : req.b;
    add_res = {1'b0, acc_r} + (sh_r[0] ? {1'b0, opb_r} : 33'd0);
    rem_sh  = {acc_r, sh_r[31]};
    sub_res = rem_sh - {1'b0, opb_r};
    prod    = {acc_r, sh_r};
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    is_div_nxt = is_div_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    zero_nxt   = zero_r;
    acc_nxt    = acc_r;
    sh_nxt     = sh_r;
    opb_nxt    = opb_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          state_nxt  = S_RUN;
          cnt_nxt    = 5'd31;
          is_div_nxt = req.is_div;
          neg_q_nxt  = na ^ nb;
          neg_r_nxt  = na;
          zero_nxt   = (req.b == 32'd0);
          acc_nxt    = 32'd0;
          sh_nxt     = ua;
          opb_nxt    = ub;
        end
      end
      S_RUN: begin
        if (is_div_r) begin
          if (!sub_res[32]) begin
            acc_nxt = sub_res[31:0];
            sh_nxt  = {sh_r[30:0], 1'b1};
          end else begin
            acc_nxt = rem_sh[31:0];
            sh_nxt  = {sh_r[30:0], 1'b0};
          end
        end else begin
          acc_nxt = add_res[32:1];
          sh_nxt  = {add_res[0], sh_r[31:1]};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) state_nxt = S_FIX;
      end
      S_FIX: begin
        // sign fixup; a zero divisor gives zero HI and LO
        if (is_div_r) begin
          if (zero_r) begin
            acc_nxt = 32'd0;
            sh_nxt  = 32'd0;
          end else begin
            if (neg_q_r) sh_nxt = 32'd0 - sh_r;
            if (neg_r_r) acc_nxt = 32'd0 - acc_r;
          end
        end else if (neg_q_r) begin
          {acc_nxt, sh_nxt} = 64'd0 - prod;
        end
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r    <= cnt_nxt;
    is_div_r <= is_div_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_r_r  <= neg_r_nxt;
    zero_r   <= zero_nxt;
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    opb_r    <= opb_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.hi   = acc_r;
  assign rsp.lo   = sh_r;

endmodule

@@ src/rdem_alu.sv @@
// Combinational decode of every instruction and execute of everything but multiply/divide.
module rdem_alu import rdem_pkg::*; (
  input  in_item_t    item,
  input  logic [31:0] hi,
  input  logic [31:0] lo,
  input  logic        busy,
  output out_item_t   res,
  output logic        is_md,
  output logic        md_div,
  output logic        md_signed,
  output logic        wr_hi,
  output logic        wr_lo
);

  logic [5:0]  op, fn;
  logic [4:0]  rtn, rdn, sh, vsh;
  logic [15:0] imm;
  logic [31:0] se, next, btarg, rs, rt;
  logic        wr;

  always_comb begin
    op    = item.instr_word[31:26];
    rtn   = item.instr_word[20:16];
    rdn   = item.instr_word[15:11];
    sh    = item.instr_word[10:6];
    fn    = item.instr_word[5:0];
    imm   = item.instr_word[15:0];
    rs    = item.rs_value;
    rt    = item.rt_value;
    vsh   = rs[4:0];
    se    = {{16{imm[15]}}, imm};
    next  = item.pc_value + 32'd4;
    btarg = next + {se[29:0], 2'b00};
    res       = '0;
    wr        = 1'b0;
    is_md     = 1'b0;
    md_div    = 1'b0;
    md_signed = 1'b0;
    wr_hi     = 1'b0;
    wr_lo     = 1'b0;
    res.accepted = item.cmd;
    case (op)
      OP_RTYPE: begin
        res.reg_index = rdn;
        wr = 1'b1;
        case (fn)
          FN_SLL:  res.reg_value = rt << sh;
          FN_SRL:  res.reg_value = rt >> sh;
          FN_SRA:  res.reg_value = $unsigned($signed(rt) >>> sh);
          FN_SLLV: res.reg_value = rt << vsh;
          FN_SRLV: res.reg_value = rt >> vsh;
          FN_SRAV: res.reg_value = $unsigned($signed(rt) >>> vsh);
          FN_JR: begin
            wr = 1'b0; res.reg_index = 5'd0;
            res.br_flag = 1'b1; res.br_taken = 1'b1; res.branch_target = rs;
          end
          FN_JALR: begin
            res.reg_value = next;
            res.br_flag = 1'b1; res.br_taken = 1'b1; res.branch_target = rs;
          end
          FN_MFHI, FN_MFLO: begin
            if (busy) begin
              res.accepted = 1'b0;
            end else begin
              res.reg_value = (fn == FN_MFHI) ? hi : lo;
            end
          end
          FN_MTHI, FN_MTLO: begin
            wr = 1'b0; res.reg_index = 5'd0;
            if (busy) res.accepted = 1'b0;
            else if (fn == FN_MTHI) wr_hi = 1'b1;
            else wr_lo = 1'b1;
          end
          FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
            wr = 1'b0; res.reg_index = 5'd0;
            is_md     = 1'b1;
            md_div    = fn[1];
            md_signed = !fn[0];
          end
          FN_ADD, FN_ADDU: res.reg_value = rs + rt;
          FN_SUB, FN_SUBU: res.reg_value = rs - rt;
          FN_AND:  res.reg_value = rs & rt;
          FN_OR:   res.reg_value = rs | rt;
          FN_XOR:  res.reg_value = rs ^ rt;
          FN_NOR:  res.reg_value = ~(rs | rt);
          FN_SLT:  res.reg_value = {31'd0, $signed(rs) < $signed(rt)};
          FN_SLTU: res.reg_value = {31'd0, rs < rt};
          default: begin
            wr = 1'b0; res.reg_index = 5'd0;
          end
        endcase
      end
      OP_REGIMM: begin
        if (rtn[3:1] == 3'd0) begin
          res.br_flag       = 1'b1;
          res.branch_target = btarg;
          res.br_taken      = rtn[0] ? !rs[31] : rs[31];
          if (rtn[4]) begin
            wr = 1'b1; res.reg_index = REG_RA; res.reg_value = next;
          end
        end
      end
      OP_J, OP_JAL: begin
        res.br_flag = 1'b1; res.br_taken = 1'b1;
        res.branch_target = {next[31:28], item.instr_word[25:0], 2'b00};
        if (op == OP_JAL) begin
          wr = 1'b1; res.reg_index = REG_RA; res.reg_value = next;
        end
      end
      OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
        res.br_flag = 1'b1; res.branch_target = btarg;
        case (op)
          OP_BEQ:  res.br_taken = (rs == rt);
          OP_BNE:  res.br_taken = (rs != rt);
          OP_BLEZ: res.br_taken = (rs == 32'd0) || rs[31];
          default: res.br_taken = (rs != 32'd0) && !rs[31];
        endcase
      end
      OP_ADDI, OP_ADDI_U, OP_SLTI, OP_SLTI_U, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
        wr = 1'b1; res.reg_index = rtn;
        case (op)
          OP_ADDI, OP_ADDI_U: res.reg_value = rs + se;
          OP_SLTI:   res.reg_value = {31'd0, $signed(rs) < $signed(se)};
          OP_SLTI_U: res.reg_value = {31'd0, rs < se};
          OP_ANDI:   res.reg_value = rs & {16'd0, imm};
          OP_ORI:    res.reg_value = rs | {16'd0, imm};
          OP_XORI:   res.reg_value = rs ^ {16'd0, imm};
          default:   res.reg_value = {imm, 16'd0};
        endcase
      end
      default: begin
        case (op)
          OP_LW:   res.mem_kind = MK_LW;
          OP_LH:   res.mem_kind = MK_LH;
          OP_LHU:  res.mem_kind = MK_LHU;
          OP_LB:   res.mem_kind = MK_LB;
          OP_LBU:  res.mem_kind = MK_LBU;
          OP_SW:   res.mem_kind = MK_SW;
          OP_SH:   res.mem_kind = MK_SH;
          OP_SB:   res.mem_kind = MK_SB;
          default: res.mem_kind = MK_NONE;
        endcase
        if (res.mem_kind != MK_NONE) begin
          res.mem_address = rs + se;
          if (res.mem_kind >= MK_SW) res.store_data = rt;
          else res.reg_index = rtn;
        end
      end
    endcase
    res.reg_write = wr && (res.reg_index != 5'd0);
    if (!res.accepted) begin
      res   = '0;
      is_md = 1'b0;
      wr_hi = 1'b0;
      wr_lo = 1'b0;
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench for the integer execute stage with HI/LO multiply/divide unit.
`timescale 1ns / 1ps

module tb;
  import rdem_pkg::*;

  // Predicts the stage result for each accepted tick and holds the results still due.
  class exec_scoreboard;
    logic [31:0] hi_q, lo_q;
    logic [5:0]  busy_q, mul_lat, div_lat;
    out_item_t   due[$];
    int          errors;

    function new();
      hi_q = '0; lo_q = '0; busy_q = '0;
      mul_lat = 6'd4; div_lat = 6'd32;
      errors = 0;
    endfunction

    function void set_latency(logic [0:0] idx, logic [5:0] v);
      if (idx == CFG_MUL_LAT) mul_lat = v;
      else div_lat = v;
    endfunction

    function out_item_t execute(in_item_t it);
      out_item_t   r;
      logic [31:0] ins, rs, rt, imm, se, nxt, btarg, ua, ub, q, rm;
      logic [5:0]  op, fn;
      logic [4:0]  rtn, rdn, sh;
      logic [63:0] p;
      logic        na, nb;
      r = '0;
      ins = it.instr_word; rs = it.rs_value; rt = it.rt_value;
      op = ins[31:26]; rtn = ins[20:16]; rdn = ins[15:11]; sh = ins[10:6]; fn = ins[5:0];
      imm = {16'h0, ins[15:0]};
      se = {{16{ins[15]}}, ins[15:0]};
      nxt = it.pc_value + 32'd4;
      btarg = nxt + (se << 2);
      if (busy_q != 0) busy_q = busy_q - 6'd1;
      if (!it.cmd) return r;
      r.accepted = 1'b1;
      case (op)
        OP_RTYPE: begin
          r.reg_index = rdn;
          r.reg_write = 1'b1;
          case (fn)
            FN_SLL:  r.reg_value = rt << sh;
            FN_SRL:  r.reg_value = rt >> sh;
            FN_SRA:  r.reg_value = $signed(rt) >>> sh;
            FN_SLLV: r.reg_value = rt << rs[4:0];
            FN_SRLV: r.reg_value = rt >> rs[4:0];
            FN_SRAV: r.reg_value = $signed(rt) >>> rs[4:0];
            FN_JR: begin
              r.reg_write = 0; r.reg_index = 0;
              r.br_flag = 1; r.br_taken = 1; r.branch_target = rs;
            end
            FN_JALR: begin
              r.reg_value = nxt;
              r.br_flag = 1; r.br_taken = 1; r.branch_target = rs;
            end
            FN_MFHI, FN_MFLO: begin
              if (busy_q != 0) return '0;   // HI/LO interlock: refused
              r.reg_value = (fn == FN_MFHI) ? hi_q : lo_q;
            end
            FN_MTHI, FN_MTLO: begin
              if (busy_q != 0) return '0;
              r.reg_write = 0; r.reg_index = 0;
              if (fn == FN_MTHI) hi_q = rs; else lo_q = rs;
            end
            FN_MULT, FN_MULTU: begin
              if (fn == FN_MULT)
                p = $signed({{32{rs[31]}}, rs}) * $signed({{32{rt[31]}}, rt});
              else
                p = {32'h0, rs} * {32'h0, rt};
              hi_q = p[63:32]; lo_q = p[31:0];
              busy_q = mul_lat;
              r.reg_write = 0; r.reg_index = 0;
            end
            FN_DIV, FN_DIVU: begin
              if (rt == 0) begin
                hi_q = 0; lo_q = 0;
              end else if (fn == FN_DIVU) begin
                lo_q = rs / rt; hi_q = rs % rt;
              end else begin
                // magnitudes, then signs; 0x80000000 / -1 falls out as LO = 0x80000000
                na = rs[31]; nb = rt[31];
                ua = na ? -rs : rs;
                ub = nb ? -rt : rt;
                q = ua / ub; rm = ua % ub;
                lo_q = (na != nb) ? -q : q;
                hi_q = na ? -rm : rm;
              end
              busy_q = div_lat;
              r.reg_write = 0; r.reg_index = 0;
            end
            FN_ADD, FN_ADDU: r.reg_value = rs + rt;
            FN_SUB, FN_SUBU: r.reg_value = rs - rt;
            FN_AND:  r.reg_value = rs & rt;
            FN_OR:   r.reg_value = rs | rt;
            FN_XOR:  r.reg_value = rs ^ rt;
            FN_NOR:  r.reg_value = ~(rs | rt);
            FN_SLT:  r.reg_value = ($signed(rs) < $signed(rt)) ? 32'd1 : 32'd0;
            FN_SLTU: r.reg_value = (rs < rt) ? 32'd1 : 32'd0;
            default: begin
              r.reg_write = 0; r.reg_index = 0;
            end
          endcase
        end
        OP_REGIMM: begin
          if (rtn == 5'h00 || rtn == 5'h01 || rtn == 5'h10 || rtn == 5'h11) begin
            r.br_flag = 1;
            r.branch_target = btarg;
            r.br_taken = rtn[0] ? !rs[31] : rs[31];
            if (rtn[4]) begin
              r.reg_write = 1; r.reg_index = REG_RA; r.reg_value = nxt;
            end
          end
        end
        OP_J, OP_JAL: begin
          r.br_flag = 1; r.br_taken = 1;
          r.branch_target = {nxt[31:28], ins[25:0], 2'b00};
          if (op == OP_JAL) begin
            r.reg_write = 1; r.reg_index = REG_RA; r.reg_value = nxt;
          end
        end
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
          r.br_flag = 1; r.branch_target = btarg;
          case (op)
            OP_BEQ:  r.br_taken = (rs == rt);
            OP_BNE:  r.br_taken = (rs != rt);
            OP_BLEZ: r.br_taken = (rs == 0) || rs[31];
            default: r.br_taken = (rs != 0) && !rs[31];
          endcase
        end
        OP_ADDI, OP_ADDI_U, OP_SLTI, OP_SLTI_U, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
          r.reg_write = 1; r.reg_index = rtn;
          case (op)
            OP_ADDI, OP_ADDI_U: r.reg_value = rs + se;
            OP_SLTI:   r.reg_value = ($signed(rs) < $signed(se)) ? 32'd1 : 32'd0;
            OP_SLTI_U: r.reg_value = (rs < se) ? 32'd1 : 32'd0;
            OP_ANDI:   r.reg_value = rs & imm;
            OP_ORI:    r.reg_value = rs | imm;
            OP_XORI:   r.reg_value = rs ^ imm;
            default:   r.reg_value = imm << 16;
          endcase
        end
        default: begin
          case (op)
            OP_LW:   r.mem_kind = MK_LW;
            OP_LH:   r.mem_kind = MK_LH;
            OP_LHU:  r.mem_kind = MK_LHU;
            OP_LB:   r.mem_kind = MK_LB;
            OP_LBU:  r.mem_kind = MK_LBU;
            OP_SW:   r.mem_kind = MK_SW;
            OP_SH:   r.mem_kind = MK_SH;
            OP_SB:   r.mem_kind = MK_SB;
            default: r.mem_kind = MK_NONE;
          endcase
          if (r.mem_kind != MK_NONE) begin
            r.mem_address = rs + se;
            if (r.mem_kind >= MK_SW) r.store_data = rt;
            else r.reg_index = rtn;   // load: no write here, data comes later
          end
        end
      endcase
      if (r.reg_index == 0) r.reg_write = 0;
      return r;
    endfunction

    function void note_input(in_item_t it);
      due.push_back(execute(it));
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = due.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("reg_write", want.reg_write, got.reg_write);
      compare("reg_index", want.reg_index, got.reg_index);
      compare("reg_value", want.reg_value, got.reg_value);
      compare("br_flag", want.br_flag, got.br_flag);
      compare("br_taken", want.br_taken, got.br_taken);
      compare("branch_target", want.branch_target, got.branch_target);
      compare("mem_kind", want.mem_kind, got.mem_kind);
      compare("mem_address", want.mem_address, got.mem_address);
      compare("store_data", want.store_data, got.store_data);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [5:0] cfg_data;
  logic       send_burst;   // sender never gaps while set
  logic       recv_burst;   // receiver never stalls while set

  rdem_in_if  in_ch();
  rdem_out_if out_ch();

  exec_scoreboard sb = new();

  risc_decode_execute_muldiv DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // All results are checked against the oldest prediction on each transfer.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Receiver: random stall before each result, none in burst stretches.
  initial begin : receiver
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // Watchdog: far beyond the slowest correct run (divides plus both idlings).
  initial begin
    #20000000;
    $display("tb failed");
    $finish;
  end

  function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rsn, logic [4:0] rtn,
                                         logic [4:0] rdn, logic [4:0] sh);
    return {OP_RTYPE, rsn, rtn, rdn, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rsn, logic [4:0] rtn,
                                         logic [15:0] imm);
    return {op, rsn, rtn, imm};
  endfunction

  // Operand values lean on the corners.
  function automatic logic [31:0] operand();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [5:0] alu_fns[] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
                              FN_JALR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
                              FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [5:0] md_fns[]  = '{FN_MULT, FN_MULTU, FN_DIV, FN_DIVU};
    logic [5:0] hl_fns[]  = '{FN_MFHI, FN_MFLO, FN_MTHI, FN_MTLO};
    logic [5:0] br_ops[]  = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
    logic [5:0] im_ops[]  = '{OP_ADDI, OP_ADDI_U, OP_SLTI, OP_SLTI_U, OP_ANDI, OP_ORI,
                              OP_XORI, OP_LUI};
    logic [5:0] mem_ops[] = '{OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB};
    logic [4:0] regimm_rt[] = '{5'h00, 5'h01, 5'h10, 5'h11};
    logic [31:0] w;
    int k;
    w = $urandom;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      w[31:26] = OP_RTYPE; w[5:0] = alu_fns[$urandom_range(0, 17)];
    end else if (k < 42) begin
      w[31:26] = OP_RTYPE; w[5:0] = md_fns[$urandom_range(0, 3)];
    end else if (k < 58) begin
      w[31:26] = OP_RTYPE; w[5:0] = hl_fns[$urandom_range(0, 3)];
    end else if (k < 70) begin
      w[31:26] = br_ops[$urandom_range(0, 6)];
      if (w[31:26] == OP_REGIMM && $urandom_range(0, 4) != 0)
        w[20:16] = regimm_rt[$urandom_range(0, 3)];
    end
    else if (k < 82) w[31:26] = im_ops[$urandom_range(0, 7)];
    else if (k < 94) w[31:26] = mem_ops[$urandom_range(0, 7)];
    // else: raw word, covers unknown opcodes and functions
    return w;
  endfunction

  task automatic send_item(logic cmd, logic [31:0] ins, logic [31:0] pc,
                           logic [31:0] rs, logic [31:0] rt);
    in_item_t it;
    int gap;
    it.cmd = cmd; it.instr_word = ins; it.pc_value = pc;
    it.rs_value = rs; it.rt_value = rt;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  // Sender holds off until every predicted result has been transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_latencies(logic [5:0] mul_v, logic [5:0] div_v);
    cfg_we <= 1'b1; cfg_index <= CFG_MUL_LAT; cfg_data <= mul_v;
    @(posedge clk);
    cfg_index <= CFG_DIV_LAT; cfg_data <= div_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_latency(CFG_MUL_LAT, mul_v);
    sb.set_latency(CFG_DIV_LAT, div_v);
  endtask

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      send_item($urandom_range(0, 9) != 0, rand_instr(), $urandom, operand(), operand());
    end
  endtask

  initial begin
    logic [5:0] mul_set[6] = '{6'd4, 6'd0, 6'd63, 6'd1, 6'd0, 6'd0};
    logic [5:0] div_set[6] = '{6'd32, 6'd0, 6'd63, 6'd5, 6'd0, 6'd0};
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    send_burst  = 1'b0;
    recv_burst  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset latencies.
    send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // idle tick
    send_item(1'b1, r_word(FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0, 32'h7FFF_FFFF, 32'h1);
    send_item(1'b1, r_word(FN_SUB, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0, 32'h8000_0000, 32'h1);
    send_item(1'b1, i_word(OP_ADDI, 5'd1, 5'd4, 16'h8000), 32'h0, 32'h8000_0000, 32'h0);
    send_item(1'b1, r_word(FN_SRAV, 5'd1, 5'd2, 5'd5, 5'd0), 32'h0, 32'hFFFF_FFE1,
              32'h8000_0000);
    send_item(1'b1, r_word(FN_SLLV, 5'd1, 5'd2, 5'd6, 5'd0), 32'h0, 32'h0000_0023, 32'h1);
    send_item(1'b1, r_word(FN_SRA, 5'd0, 5'd2, 5'd7, 5'd31), 32'h0, 32'h0, 32'h8000_0000);
    send_item(1'b1, r_word(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0, 32'h8000_0000,
              32'hFFFF_FFFF);
    send_item(1'b1, r_word(FN_MFHI, 5'd0, 5'd0, 5'd8, 5'd0), 32'h0, 32'h0, 32'h0); // refused
    send_item(1'b1, r_word(FN_MTLO, 5'd1, 5'd0, 5'd0, 5'd0), 32'h0, 32'h5, 32'h0); // refused
    send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(1'b1, r_word(FN_MFLO, 5'd0, 5'd0, 5'd9, 5'd0), 32'h0, 32'h0, 32'h0);
    send_item(1'b1, r_word(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0, 32'h8000_0000,
              32'hFFFF_FFFF);                                        // signed overflow
    for (int i = 0; i < 32; i++) send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(1'b1, r_word(FN_MFLO, 5'd0, 5'd0, 5'd10, 5'd0), 32'h0, 32'h0, 32'h0);
    send_item(1'b1, r_word(FN_DIVU, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0, 32'h1234, 32'h0); // by zero
    send_item(1'b1, r_word(FN_JALR, 5'd1, 5'd0, 5'd0, 5'd0), 32'hFFFF_FFFC, 32'h40, 32'h0);
    send_item(1'b1, i_word(OP_REGIMM, 5'd1, 5'h10, 16'hFFFF), 32'h100, 32'h1, 32'h0);
    send_item(1'b1, i_word(OP_REGIMM, 5'd1, 5'h05, 16'h0004), 32'h100, 32'h1, 32'h0);
    send_item(1'b1, {OP_JAL, 26'h3FF_FFFF}, 32'hEFFF_FFFC, 32'h0, 32'h0);  // region from pc+4
    send_item(1'b1, i_word(OP_LB, 5'd1, 5'd0, 16'hFFFF), 32'h0, 32'h0, 32'h0);
    send_item(1'b1, i_word(OP_SB, 5'd1, 5'd2, 16'h7FFF), 32'h0, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_item(1'b1, r_word(6'h0C, 5'd0, 5'd0, 5'd0, 5'd0), 32'h0, 32'h0, 32'h0);   // syscall
    send_item(1'b1, {6'h3F, 26'h3FF_FFFF}, 32'h0, 32'h0, 32'h0);                  // unknown op

    // Random phases, each run at its own latency setting with the stage drained first.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph >= 4) write_latencies(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      else if (ph > 0) write_latencies(mul_set[ph], div_set[ph]);
      random_items(155);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
